FILE: design/gbtd_pkg.sv
// ----------------------------------------------------------------------------
// gbtd_pkg: shared types and constants for the gamepad bind trigger detector
// Commands, trigger kinds, reset values and the per-sample decision record.
// ----------------------------------------------------------------------------
package gbtd_pkg;

  typedef enum logic [2:0] {
    CMD_REST   = 3'd0,
    CMD_BUTTON = 3'd1,
    CMD_AXIS   = 3'd2,
    CMD_HAT    = 3'd3,
    CMD_EOS    = 3'd4
  } gbtd_cmd_t;

  typedef enum logic [1:0] {
    KIND_BUTTON = 2'd0,
    KIND_AXIS   = 2'd1,
    KIND_HAT    = 2'd2
  } gbtd_kind_t;

  localparam logic [15:0]        THRESHOLD_RESET = 16'd20000;
  localparam logic signed [15:0] LOCK_POS        = 16'sh7fff;
  localparam logic signed [15:0] LOCK_NEG        = -16'sh7fff;

  localparam int DEF_NUM_PORTS   = 8;
  localparam int DEF_NUM_BUTTONS = 32;
  localparam int DEF_NUM_AXES    = 8;
  localparam int DEF_NUM_HATS    = 4;

  typedef struct packed {
    logic               trig;
    gbtd_kind_t         kind;
    logic [1:0]         dir;
    logic               btn_we;
    logic               btn_wdata;
    logic               hat_we;
    logic [3:0]         hat_wdata;
    logic               rest_we;
    logic               lock_we;
    logic signed [15:0] lock_wdata;
  } gbtd_eval_t;

endpackage

FILE: design/gbtd_ram.sv
// ----------------------------------------------------------------------------
// gbtd_ram: single-port-write, single-port-read synchronous memory
// Registered read; a write to the address being read is forwarded.
// ----------------------------------------------------------------------------
module gbtd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic             byp;
  logic [WIDTH-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q     <= mem[raddr];
      byp      <= we && (waddr == raddr);
      byp_data <= wdata;
    end
  end

  assign rdata = byp ? byp_data : rd_q;

endmodule

FILE: design/gbtd_eval.sv
// ----------------------------------------------------------------------------
// gbtd_eval: trigger decision for one sample
// Button edge, axis threshold and lock, hat new-direction priority; write-backs.
// ----------------------------------------------------------------------------
module gbtd_eval (
  input  gbtd_pkg::gbtd_cmd_t cmd,
  input  logic                ok,
  input  logic                scan_found,
  input  logic                pressed,
  input  logic signed [15:0]  axis_value,
  input  logic [3:0]          hat_bits,
  input  logic [15:0]         threshold,
  input  logic                btn_prev,
  input  logic [3:0]          hat_prev,
  input  logic signed [15:0]  rest,
  input  logic signed [15:0]  lock,
  output gbtd_pkg::gbtd_eval_t res
);

  logic signed [16:0] vx;
  logic signed [16:0] dl;
  logic signed [16:0] dr;
  logic [16:0]        mag;
  logic [16:0]        ld;
  logic [16:0]        rd;
  logic [16:0]        thr;
  logic               axis_hit;
  logic               positive;
  logic [3:0]         fresh;

  always_comb begin
    vx       = {axis_value[15], axis_value};
    dl       = vx - {lock[15], lock};
    dr       = vx - {rest[15], rest};
    mag      = vx[16] ? 17'(-vx) : 17'(vx);
    ld       = dl[16] ? 17'(-dl) : 17'(dl);
    rd       = dr[16] ? 17'(-dr) : 17'(dr);
    thr      = {1'b0, threshold};
    axis_hit = (mag >= thr) && (ld >= thr) && (rd >= thr);
    positive = !axis_value[15] && (axis_value != 16'sd0);
    fresh    = hat_bits & ~hat_prev;

    res            = '0;
    res.kind       = gbtd_pkg::KIND_BUTTON;
    res.btn_wdata  = pressed;
    res.hat_wdata  = hat_bits;
    res.lock_wdata = 16'sd0;

    unique case (cmd)
      gbtd_pkg::CMD_REST: begin
        res.rest_we = ok;
      end
      gbtd_pkg::CMD_BUTTON: begin
        res.btn_we = ok;
        res.trig   = ok && !scan_found && pressed && !btn_prev;
        res.kind   = gbtd_pkg::KIND_BUTTON;
      end
      gbtd_pkg::CMD_AXIS: begin
        res.kind = gbtd_pkg::KIND_AXIS;
        res.dir  = {1'b0, positive};
        if (ok && !scan_found) begin
          if (axis_hit) begin
            res.trig       = 1'b1;
            res.lock_we    = 1'b1;
            res.lock_wdata = positive ? gbtd_pkg::LOCK_POS : gbtd_pkg::LOCK_NEG;
          end else if (ld >= thr) begin
            res.lock_we = 1'b1;
          end
        end
      end
      gbtd_pkg::CMD_HAT: begin
        res.hat_we = ok;
        res.trig   = ok && !scan_found && (fresh != 4'd0);
        res.kind   = gbtd_pkg::KIND_HAT;
        priority if (fresh[0]) res.dir = 2'd0;
        else if (fresh[1])     res.dir = 2'd1;
        else if (fresh[2])     res.dir = 2'd2;
        else                   res.dir = 2'd3;
      end
      default: begin
        res.trig = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/gamepad_bind_trigger_detect.sv
// ----------------------------------------------------------------------------
// gamepad_bind_trigger_detect: first new control actuation in a sample scan
// Previous button and hat levels, rest and lock axis values live in memories;
// each sample reads its entry, decides, and writes back in the cycle after it is accepted.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  command port control_index pressed
//                                 axis_value hat_bits
//   out      out_valid/ out_stall found trigger_kind trigger_port
//                                 trigger_index trigger_direction
//   cfg      cfg_valid/ cfg_ready cfg_data (axis_threshold)
//
// One item per cycle while in_stall is low; an end-of-scan item passes the
// stage-one register, then the output register, before its result is on out.
// Stage one reads the memories, stage two decides and writes back; same-entry
// back-to-back accesses are forwarded inside each memory. After reset a
// clearing pass zeroes every memory entry; in_stall is high during it.
// An end-of-scan item stalls input only while the output register is full
// and stalled.
// ----------------------------------------------------------------------------
module gamepad_bind_trigger_detect #(
  parameter int NUM_PORTS   = gbtd_pkg::DEF_NUM_PORTS,
  parameter int NUM_BUTTONS = gbtd_pkg::DEF_NUM_BUTTONS,
  parameter int NUM_AXES    = gbtd_pkg::DEF_NUM_AXES,
  parameter int NUM_HATS    = gbtd_pkg::DEF_NUM_HATS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        command,
  input  logic [2:0]        port,
  input  logic [4:0]        control_index,
  input  logic              pressed,
  input  logic signed [15:0] axis_value,
  input  logic [3:0]        hat_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic [1:0]        trigger_kind,
  output logic [2:0]        trigger_port,
  output logic [4:0]        trigger_index,
  output logic [1:0]        trigger_direction
);

  localparam int BTN_DEPTH  = NUM_PORTS * NUM_BUTTONS;
  localparam int HAT_DEPTH  = NUM_PORTS * NUM_HATS;
  localparam int AXIS_DEPTH = NUM_PORTS * NUM_AXES;
  localparam int BTN_AW     = (BTN_DEPTH > 1) ? $clog2(BTN_DEPTH) : 1;
  localparam int HAT_AW     = (HAT_DEPTH > 1) ? $clog2(HAT_DEPTH) : 1;
  localparam int AXIS_AW    = (AXIS_DEPTH > 1) ? $clog2(AXIS_DEPTH) : 1;
  localparam int MAX_DEPTH1 = (BTN_DEPTH > HAT_DEPTH) ? BTN_DEPTH : HAT_DEPTH;
  localparam int MAX_DEPTH  = (MAX_DEPTH1 > AXIS_DEPTH) ? MAX_DEPTH1 : AXIS_DEPTH;
  localparam int CLR_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [15:0]        threshold;
  logic               clearing;
  logic [CLR_W-1:0]   clr_cnt;

  logic               in_acc;
  logic               s1_valid;
  logic               s1_block;
  logic               s1_fire;
  gbtd_pkg::gbtd_cmd_t s1_cmd;
  logic               s1_ok;
  logic [2:0]         s1_port;
  logic [4:0]         s1_index;
  logic               s1_pressed;
  logic signed [15:0] s1_value;
  logic [3:0]         s1_hat;
  logic [BTN_AW-1:0]  s1_btn_addr;
  logic [HAT_AW-1:0]  s1_hat_addr;
  logic [AXIS_AW-1:0] s1_axis_addr;

  gbtd_pkg::gbtd_cmd_t in_cmd;
  logic               port_ok;
  logic               in_ok;
  logic [9:0]         btn_full;
  logic [9:0]         hat_full;
  logic [9:0]         axis_full;
  logic [BTN_AW-1:0]  btn_addr;
  logic [HAT_AW-1:0]  hat_addr;
  logic [AXIS_AW-1:0] axis_addr;

  logic               scan_found;
  gbtd_pkg::gbtd_kind_t rec_kind;
  logic [2:0]         rec_port;
  logic [4:0]         rec_index;
  logic [1:0]         rec_dir;

  logic               btn_rdata;
  logic [3:0]         hat_rdata;
  logic [15:0]        rest_rdata;
  logic [15:0]        lock_rdata;
  gbtd_pkg::gbtd_eval_t ev;

  logic               btn_we;
  logic               btn_wdata;
  logic [BTN_AW-1:0]  btn_waddr;
  logic               hat_we;
  logic [3:0]         hat_wdata;
  logic [HAT_AW-1:0]  hat_waddr;
  logic               rest_we;
  logic [15:0]        rest_wdata;
  logic               lock_we;
  logic [15:0]        lock_wdata;
  logic [AXIS_AW-1:0] axis_waddr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gbtd_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // clearing pass over all memories
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
      if (clr_cnt == CLR_W'(MAX_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // stage one: decode and address
  always_comb begin
    in_cmd = gbtd_pkg::gbtd_cmd_t'(command);
    port_ok = 5'(port) < 5'(NUM_PORTS);
    unique case (in_cmd)
      gbtd_pkg::CMD_REST:   in_ok = port_ok && (6'(control_index) < 6'(NUM_AXES));
      gbtd_pkg::CMD_BUTTON: in_ok = port_ok && (6'(control_index) < 6'(NUM_BUTTONS));
      gbtd_pkg::CMD_AXIS:   in_ok = port_ok && (6'(control_index) < 6'(NUM_AXES));
      gbtd_pkg::CMD_HAT:    in_ok = port_ok && (6'(control_index) < 6'(NUM_HATS));
      default:              in_ok = 1'b0;
    endcase
    btn_full  = 10'(port) * 10'(NUM_BUTTONS) + 10'(control_index);
    hat_full  = 10'(port) * 10'(NUM_HATS) + 10'(control_index);
    axis_full = 10'(port) * 10'(NUM_AXES) + 10'(control_index);
    btn_addr  = btn_full[BTN_AW-1:0];
    hat_addr  = hat_full[HAT_AW-1:0];
    axis_addr = axis_full[AXIS_AW-1:0];
  end

  assign s1_block = s1_valid && (s1_cmd == gbtd_pkg::CMD_EOS) && out_valid && out_stall;
  assign s1_fire  = s1_valid && !s1_block;
  assign in_stall = clearing || s1_block;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd       <= in_cmd;
      s1_ok        <= in_ok;
      s1_port      <= port;
      s1_index     <= control_index;
      s1_pressed   <= pressed;
      s1_value     <= axis_value;
      s1_hat       <= hat_bits;
      s1_btn_addr  <= btn_addr;
      s1_hat_addr  <= hat_addr;
      s1_axis_addr <= axis_addr;
    end
  end

  // write-back ports, zero fill while clearing
  always_comb begin
    btn_we     = clearing || (s1_fire && ev.btn_we);
    hat_we     = clearing || (s1_fire && ev.hat_we);
    rest_we    = clearing || (s1_fire && ev.rest_we);
    lock_we    = clearing || (s1_fire && ev.lock_we);
    btn_wdata  = clearing ? 1'b0 : ev.btn_wdata;
    hat_wdata  = clearing ? 4'd0 : ev.hat_wdata;
    rest_wdata = clearing ? 16'd0 : s1_value;
    lock_wdata = clearing ? 16'd0 : ev.lock_wdata;
    btn_waddr  = clearing ? clr_cnt[BTN_AW-1:0] : s1_btn_addr;
    hat_waddr  = clearing ? clr_cnt[HAT_AW-1:0] : s1_hat_addr;
    axis_waddr = clearing ? clr_cnt[AXIS_AW-1:0] : s1_axis_addr;
  end

  gbtd_ram #(.WIDTH(1), .DEPTH(BTN_DEPTH)) u_btn_ram (
    .clk   (clk),
    .we    (btn_we),
    .waddr (btn_waddr),
    .wdata (btn_wdata),
    .re    (in_acc),
    .raddr (btn_addr),
    .rdata (btn_rdata)
  );

  gbtd_ram #(.WIDTH(4), .DEPTH(HAT_DEPTH)) u_hat_ram (
    .clk   (clk),
    .we    (hat_we),
    .waddr (hat_waddr),
    .wdata (hat_wdata),
    .re    (in_acc),
    .raddr (hat_addr),
    .rdata (hat_rdata)
  );

  gbtd_ram #(.WIDTH(16), .DEPTH(AXIS_DEPTH)) u_rest_ram (
    .clk   (clk),
    .we    (rest_we),
    .waddr (axis_waddr),
    .wdata (rest_wdata),
    .re    (in_acc),
    .raddr (axis_addr),
    .rdata (rest_rdata)
  );

  gbtd_ram #(.WIDTH(16), .DEPTH(AXIS_DEPTH)) u_lock_ram (
    .clk   (clk),
    .we    (lock_we),
    .waddr (axis_waddr),
    .wdata (lock_wdata),
    .re    (in_acc),
    .raddr (axis_addr),
    .rdata (lock_rdata)
  );

  gbtd_eval u_eval (
    .cmd        (s1_cmd),
    .ok         (s1_ok),
    .scan_found (scan_found),
    .pressed    (s1_pressed),
    .axis_value (s1_value),
    .hat_bits   (s1_hat),
    .threshold  (threshold),
    .btn_prev   (btn_rdata),
    .hat_prev   (hat_rdata),
    .rest       ($signed(rest_rdata)),
    .lock       ($signed(lock_rdata)),
    .res        (ev)
  );

  // scan record
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_found <= 1'b0;
      rec_kind   <= gbtd_pkg::KIND_BUTTON;
      rec_port   <= '0;
      rec_index  <= '0;
      rec_dir    <= '0;
    end else if (s1_fire && (s1_cmd == gbtd_pkg::CMD_EOS)) begin
      scan_found <= 1'b0;
      rec_kind   <= gbtd_pkg::KIND_BUTTON;
      rec_port   <= '0;
      rec_index  <= '0;
      rec_dir    <= '0;
    end else if (s1_fire && ev.trig) begin
      scan_found <= 1'b1;
      rec_kind   <= ev.kind;
      rec_port   <= s1_port;
      rec_index  <= s1_index;
      rec_dir    <= ev.dir;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && (s1_cmd == gbtd_pkg::CMD_EOS)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_cmd == gbtd_pkg::CMD_EOS)) begin
      found             <= scan_found;
      trigger_kind      <= rec_kind;
      trigger_port      <= rec_port;
      trigger_index     <= rec_index;
      trigger_direction <= rec_dir;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gamepad_bind_trigger_detect
// Drives gamepad sample scans (buttons, axes, hats, rest captures, noise and
// end-of-scan items) under random input gaps and output stalls, predicts each
// random end-of-scan report from a behavioral copy of the detector state, holds
// directed ones to pinned values, and compares every report field by field. The
// axis threshold is swept between idle phases, its extremes included.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_NEG   = 2'd0;
  localparam logic [1:0] DIR_POS   = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEM_TARGET   = 1100;
  localparam int NUM_PHASES    = 5;

  typedef struct packed {
    logic [2:0]         command;
    logic [2:0]         port;
    logic [4:0]         control_index;
    logic               pressed;
    logic signed [15:0] axis_value;
    logic [3:0]         hat_bits;
  } sample_t;

  typedef struct packed {
    logic       found;
    logic [1:0] kind;
    logic [2:0] port;
    logic [4:0] index;
    logic [1:0] dir;
  } report_t;

  typedef struct packed {
    sample_t s;
    logic    pin;
    report_t want;
  } drow_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [15:0]       cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        command;
  logic [2:0]        port;
  logic [4:0]        control_index;
  logic              pressed;
  logic signed [15:0] axis_value;
  logic [3:0]        hat_bits;
  logic              out_valid;
  logic              out_stall;
  logic              found;
  logic [1:0]        trigger_kind;
  logic [2:0]        trigger_port;
  logic [4:0]        trigger_index;
  logic [1:0]        trigger_direction;

  // detector copy
  logic               btn_prev [0:gbtd_pkg::DEF_NUM_PORTS*gbtd_pkg::DEF_NUM_BUTTONS-1];
  logic [3:0]         hat_prev [0:gbtd_pkg::DEF_NUM_PORTS*gbtd_pkg::DEF_NUM_HATS-1];
  logic signed [15:0] rest_val [0:gbtd_pkg::DEF_NUM_PORTS*gbtd_pkg::DEF_NUM_AXES-1];
  logic signed [15:0] lock_val [0:gbtd_pkg::DEF_NUM_PORTS*gbtd_pkg::DEF_NUM_AXES-1];
  logic               scan_hit;
  report_t            scan_rec;
  logic [15:0]        threshold;

  report_t expected_reports[$];
  sample_t scan_q[$];
  drow_t   directed [24];
  int      phase_thr [NUM_PHASES];

  bit      cur_pin;
  report_t cur_want;
  bit      quiet;
  int      live_items;
  int      mismatches;
  int      reports_seen;
  int      hits_by_kind [3];
  int      stall_left;
  int      live_goal;

  gamepad_bind_trigger_detect u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .command           (command),
    .port              (port),
    .control_index     (control_index),
    .pressed           (pressed),
    .axis_value        (axis_value),
    .hat_bits          (hat_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .found             (found),
    .trigger_kind      (trigger_kind),
    .trigger_port      (trigger_port),
    .trigger_index     (trigger_index),
    .trigger_direction (trigger_direction)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic report_t hit(input gbtd_pkg::gbtd_kind_t k, input int p, input int i,
                                  input logic [1:0] d);
    hit = {1'b1, k, p[2:0], i[4:0], d};
  endfunction

  function automatic drow_t row(input logic [2:0] c, input int p, input int i,
                                input bit pr, input int v, input int h,
                                input bit pin, input report_t want);
    row.s.command       = c;
    row.s.port          = p[2:0];
    row.s.control_index = i[4:0];
    row.s.pressed       = pr;
    row.s.axis_value    = v[15:0];
    row.s.hat_bits      = h[3:0];
    row.pin             = pin;
    row.want            = want;
  endfunction

  // advance the detector copy by one accepted item
  task automatic detect_step(input sample_t s, output bit emits, output bit live,
                             output report_t r);
    int v;
    int mag;
    int ld;
    int rd;
    int thr;
    int a;
    logic [3:0] fresh;
    emits = 1'b0;
    live  = 1'b1;
    r     = '0;
    v     = $signed(s.axis_value);
    thr   = int'(threshold);
    if (s.command == gbtd_pkg::CMD_EOS) begin
      emits    = 1'b1;
      r        = scan_hit ? scan_rec : report_t'(0);
      scan_hit = 1'b0;
      scan_rec = '0;
    end else if (s.command > gbtd_pkg::CMD_EOS) begin
      live = 1'b0;
    end else if (s.command == gbtd_pkg::CMD_REST) begin
      if (s.control_index < gbtd_pkg::DEF_NUM_AXES) begin
        rest_val[s.port*gbtd_pkg::DEF_NUM_AXES + s.control_index] = s.axis_value;
      end else begin
        live = 1'b0;
      end
    end else if (s.command == gbtd_pkg::CMD_BUTTON) begin
      a = s.port*gbtd_pkg::DEF_NUM_BUTTONS + s.control_index;
      if (!scan_hit && s.pressed && !btn_prev[a]) begin
        scan_hit = 1'b1;
        scan_rec = hit(gbtd_pkg::KIND_BUTTON, s.port, s.control_index, DIR_NONE);
      end
      btn_prev[a] = s.pressed;
    end else if (s.command == gbtd_pkg::CMD_AXIS) begin
      if (s.control_index >= gbtd_pkg::DEF_NUM_AXES) begin
        live = 1'b0;
      end else if (!scan_hit) begin
        a   = s.port*gbtd_pkg::DEF_NUM_AXES + s.control_index;
        mag = (v < 0) ? -v : v;
        ld  = v - int'(lock_val[a]);
        rd  = v - int'(rest_val[a]);
        if (ld < 0) ld = -ld;
        if (rd < 0) rd = -rd;
        if (mag >= thr && ld >= thr && rd >= thr) begin
          scan_hit    = 1'b1;
          scan_rec    = hit(gbtd_pkg::KIND_AXIS, s.port, s.control_index,
                            (v > 0) ? DIR_POS : DIR_NEG);
          lock_val[a] = (v > 0) ? gbtd_pkg::LOCK_POS : gbtd_pkg::LOCK_NEG;
        end else if (ld >= thr) begin
          lock_val[a] = '0;
        end
      end
    end else begin
      if (s.control_index < gbtd_pkg::DEF_NUM_HATS) begin
        a     = s.port*gbtd_pkg::DEF_NUM_HATS + s.control_index;
        fresh = s.hat_bits & ~hat_prev[a];
        if (!scan_hit && fresh != 4'd0) begin
          scan_hit = 1'b1;
          scan_rec = hit(gbtd_pkg::KIND_HAT, s.port, s.control_index,
                         fresh[0] ? DIR_UP : fresh[1] ? DIR_DOWN :
                         fresh[2] ? DIR_LEFT : DIR_RIGHT);
        end
        hat_prev[a] = s.hat_bits;
      end else begin
        live = 1'b0;
      end
    end
  endtask

  // accept items into the copy, check reports against the oldest expectation
  always @(posedge clk) begin
    bit      emits;
    bit      live;
    report_t r;
    report_t want;
    report_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        detect_step({command, port, control_index, pressed, axis_value, hat_bits},
                    emits, live, r);
        if (live) live_items <= live_items + 1;
        if (emits) expected_reports.push_back(cur_pin ? cur_want : r);
      end
      if (out_valid && !out_stall) begin
        got = {found, trigger_kind, trigger_port, trigger_index, trigger_direction};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected report at %0t: found=%0d kind=%0d port=%0d %s%0d dir=%0d",
                     $realtime, got.found, got.kind, got.port, "index=", got.index,
                     got.dir);
        end else begin
          want = expected_reports.pop_front();
          reports_seen++;
          if (got.found) hits_by_kind[got.kind]++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("report %0d at %0t: expected found=%0d kind=%0d port=%0d %s%0d dir=%0d",
                       reports_seen, $realtime, want.found, want.kind, want.port,
                       "index=", want.index, want.dir);
              $display("  got found=%0d kind=%0d port=%0d index=%0d dir=%0d",
                       got.found, got.kind, got.port, got.index, got.dir);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic send_sample(input sample_t s, input bit pin, input report_t want);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid      = 1'b1;
    command       = s.command;
    port          = s.port;
    control_index = s.control_index;
    pressed       = s.pressed;
    axis_value    = s.axis_value;
    hat_bits      = s.hat_bits;
    cur_pin       = pin;
    cur_want      = want;
    do @(posedge clk); while (in_stall);
  endtask

  // hold input until every report is in, then let the pipe settle
  task automatic drain();
    do begin
      @(negedge clk);
      in_valid = 1'b0;
    end while (expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    threshold = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic sample_t rand_sample();
    rand_sample.command       = 3'($urandom_range(0, 7));
    rand_sample.port          = 3'($urandom_range(0, 7));
    rand_sample.control_index = 5'($urandom_range(0, 31));
    rand_sample.pressed       = 1'($urandom_range(0, 1));
    rand_sample.axis_value    = 16'($urandom_range(0, 65535));
    rand_sample.hat_bits      = 4'($urandom_range(0, 15));
  endfunction

  function automatic logic signed [15:0] pick_axis();
    int v;
    case ($urandom_range(0, 4))
      0: v = 0;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = -32767;
          default: v = 0;
        endcase
      end
      2: begin
        v = int'(threshold) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      3: v = int'($urandom_range(0, 6)) - 3;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v == 0 && $urandom_range(0, 1) == 1) v = int'($urandom_range(0, 65535)) - 32768;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    pick_axis = v[15:0];
  endfunction

  // one scan: 1-3 ports of buttons, axes and hats, then end of scan
  task automatic build_scan();
    int nports;
    int p0;
    int k;
    sample_t s;
    scan_q.delete();
    nports = $urandom_range(1, 3);
    p0     = $urandom_range(0, 7);
    for (k = 0; k < nports; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        s = rand_sample();
        s.command       = gbtd_pkg::CMD_REST;
        s.port          = 3'((p0 + k) % 8);
        s.control_index = 5'($urandom_range(0, 9));
        s.axis_value    = pick_axis();
        scan_q.push_back(s);
      end
      repeat ($urandom_range(0, 3)) begin
        s = rand_sample();
        s.command       = gbtd_pkg::CMD_BUTTON;
        s.port          = 3'((p0 + k) % 8);
        s.control_index = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                                         5'($urandom_range(0, 5));
        scan_q.push_back(s);
      end
      repeat ($urandom_range(0, 2)) begin
        s = rand_sample();
        s.command       = gbtd_pkg::CMD_AXIS;
        s.port          = 3'((p0 + k) % 8);
        s.control_index = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(8, 31)) :
                                                         5'($urandom_range(0, 3));
        s.axis_value    = pick_axis();
        scan_q.push_back(s);
      end
      repeat ($urandom_range(0, 2)) begin
        s = rand_sample();
        s.command       = gbtd_pkg::CMD_HAT;
        s.port          = 3'((p0 + k) % 8);
        s.control_index = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(4, 31)) :
                                                         5'($urandom_range(0, 3));
        scan_q.push_back(s);
      end
      if ($urandom_range(0, 9) == 0) scan_q.push_back(rand_sample());
    end
    s = rand_sample();
    s.command = gbtd_pkg::CMD_EOS;
    scan_q.push_back(s);
  endtask

  initial begin
    int i;
    int ph;
    clk        = 1'b0;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    command    = gbtd_pkg::CMD_EOS;
    port       = '0;
    control_index = '0;
    pressed    = 1'b0;
    axis_value = '0;
    hat_bits   = '0;
    out_stall  = 1'b0;
    cur_pin    = 1'b0;
    cur_want   = '0;
    quiet      = 1'b0;
    live_items = 0;
    mismatches = 0;
    reports_seen = 0;
    stall_left = 0;
    hits_by_kind = '{0, 0, 0};
    for (i = 0; i < gbtd_pkg::DEF_NUM_PORTS*gbtd_pkg::DEF_NUM_BUTTONS; i++)
      btn_prev[i] = 1'b0;
    for (i = 0; i < gbtd_pkg::DEF_NUM_PORTS*gbtd_pkg::DEF_NUM_HATS; i++)
      hat_prev[i] = '0;
    for (i = 0; i < gbtd_pkg::DEF_NUM_PORTS*gbtd_pkg::DEF_NUM_AXES; i++) begin
      rest_val[i] = '0;
      lock_val[i] = '0;
    end
    scan_hit  = 1'b0;
    scan_rec  = '0;
    threshold = gbtd_pkg::THRESHOLD_RESET;

    directed = '{
      row(gbtd_pkg::CMD_EOS,    0,  0, 0,      0,  0, 1, report_t'(0)),
      row(gbtd_pkg::CMD_BUTTON, 7, 31, 1,      0,  0, 0, report_t'(0)),
      row(gbtd_pkg::CMD_EOS,    0,  0, 0,      0,  0, 1,
          hit(gbtd_pkg::KIND_BUTTON, 7, 31, DIR_NONE)),
      row(gbtd_pkg::CMD_BUTTON, 7, 31, 1,      0,  0, 0, report_t'(0)),
      row(gbtd_pkg::CMD_EOS,    0,  0, 0,      0,  0, 1, report_t'(0)),
      row(gbtd_pkg::CMD_AXIS,   0,  0, 0,  32767,  0, 0, report_t'(0)),
      row(gbtd_pkg::CMD_BUTTON, 0,  0, 1,      0,  0, 0, report_t'(0)),
      row(gbtd_pkg::CMD_EOS,    0,  0, 0,      0,  0, 1,
          hit(gbtd_pkg::KIND_AXIS, 0, 0, DIR_POS)),
      row(gbtd_pkg::CMD_AXIS,   0,  0, 0,      0,  0, 0, report_t'(0)),
      row(gbtd_pkg::CMD_AXIS,   1,  7, 0, -32768,  0, 0, report_t'(0)),
      row(gbtd_pkg::CMD_EOS,    0,  0, 0,      0,  0, 1,
          hit(gbtd_pkg::KIND_AXIS, 1, 7, DIR_NEG)),
      row(gbtd_pkg::CMD_REST,   2,  3, 0, -32768,  0, 0, report_t'(0)),
      row(gbtd_pkg::CMD_AXIS,   2,  3, 0, -32768,  0, 0, report_t'(0)),
      row(gbtd_pkg::CMD_HAT,    3,  0, 0,      0,  6, 0, report_t'(0)),
      row(gbtd_pkg::CMD_EOS,    0,  0, 0,      0,  0, 1,
          hit(gbtd_pkg::KIND_HAT, 3, 0, DIR_DOWN)),
      row(gbtd_pkg::CMD_HAT,    3,  0, 0,      0, 15, 0, report_t'(0)),
      row(gbtd_pkg::CMD_EOS,    5, 17, 1,   1234,  9, 0, report_t'(0)),
      row(gbtd_pkg::CMD_AXIS,   4,  8, 1,  32767, 15, 0, report_t'(0)),
      row(gbtd_pkg::CMD_HAT,    4,  4, 1,  32767, 15, 0, report_t'(0)),
      row(gbtd_pkg::CMD_REST,   4, 31, 1,  32767, 15, 0, report_t'(0)),
      row(3'd5,                 6,  1, 1,  32767, 15, 0, report_t'(0)),
      row(3'd6,                 6,  2, 1, -32768, 15, 0, report_t'(0)),
      row(3'd7,                 6,  3, 1,  32767, 15, 0, report_t'(0)),
      row(gbtd_pkg::CMD_EOS,    0,  0, 0,      0,  0, 1, report_t'(0))
    };
    phase_thr = '{0, 65535, 1, 12000, 0};
    phase_thr[NUM_PHASES-1] = $urandom_range(2, 40000);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_sample(directed[i].s, directed[i].pin, directed[i].want);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_threshold(phase_thr[ph][15:0]);
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      live_goal = live_items + ITEM_TARGET / NUM_PHASES;
      while (live_items < live_goal) begin
        build_scan();
        foreach (scan_q[i]) send_sample(scan_q[i], 1'b0, report_t'(0));
      end
      drain();
    end

    $display("Covered %0d samples, %0d scan reports: %0d button, %0d axis, %0d hat",
             live_items, reports_seen, hits_by_kind[0], hits_by_kind[1], hits_by_kind[2]);
    $display("Thresholds swept: 20000 0 65535 1 12000 %0d; mismatches %0d",
             phase_thr[NUM_PHASES-1], mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("run timed out with %0d reports outstanding", expected_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
design/gbtd_pkg.sv
design/gbtd_ram.sv
design/gbtd_eval.sv
design/gamepad_bind_trigger_detect.sv
tb/tb.sv
